### rtl/core/axis_select_vector_rotator_top_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the vector rotator
// used by the top module to check its handshake, stall and reset behaviour
// ----------------------------------------------------------------------------
`ifndef AXIS_SELECT_VECTOR_ROTATOR_TOP_MACROS_SVH
`define AXIS_SELECT_VECTOR_ROTATOR_TOP_MACROS_SVH

// property that must hold while out of reset
`define SVR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// property that must hold on every edge, reset included
`define SVR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/core/svr_pkg.sv
// ----------------------------------------------------------------------------
// svr_pkg
// types, constants and tables shared by the vector rotator modules
// ----------------------------------------------------------------------------
package svr_pkg;

    localparam int COORD_BITS      = 32;
    localparam int CORDIC_STAGES   = 24;
    localparam int ANGLE_BITS      = 18;
    localparam int TRIG_FRAC       = 30;
    localparam int TRIG_BITS       = 33;
    localparam int PHASE_BITS      = 32;
    localparam int FULL_TURN_UNITS = 92160;
    localparam int MAX_STAGES      = 32;

    localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = 33'sh26DD3B6A;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] angle;
        logic                         use_x_axis;
        logic                         use_y_axis;
        logic                         use_z_axis;
        logic signed [COORD_BITS-1:0] vec_x;
        logic signed [COORD_BITS-1:0] vec_y;
        logic signed [COORD_BITS-1:0] vec_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic                         saturated;
    } out_item_t;

    // valid and ready of the output handshake in the top module
    typedef struct packed {
        logic valid;
        logic ready;
    } flow_t;

    function automatic logic [PHASE_BITS-1:0] atan_entry(input int idx);
        logic [PHASE_BITS-1:0] tab [MAX_STAGES];
        tab = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
            32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
            32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
        };
        return tab[idx];
    endfunction

endpackage

### rtl/core/svr_phase.sv
// ----------------------------------------------------------------------------
// svr_phase
// reduces the angle modulo one turn and scales it to a 32-bit phase
// ----------------------------------------------------------------------------
module svr_phase (
    input  logic                                   aclk,
    input  logic                                   adv,
    input  logic signed [svr_pkg::ANGLE_BITS-1:0]  angle,
    output logic [svr_pkg::PHASE_BITS-1:0]         phase_reg
);

    localparam int RED_BITS     = 17;
    localparam int ANGLE_BITS_P = svr_pkg::ANGLE_BITS;
    localparam int TURN_DIV     = 45;
    localparam int FRAC_BITS    = 21;
    localparam int QUO_BITS     = svr_pkg::PHASE_BITS - FRAC_BITS;
    localparam int REM_BITS     = 6;
    localparam int RECIP_SHIFT  = 22;
    localparam int PROD_BITS    = 2 * RED_BITS;
    // ceil(2^22 / 45), exact quotient over the reduced range
    localparam logic [RED_BITS-1:0] RECIP =
        RED_BITS'((64'd1 << RECIP_SHIFT) / TURN_DIV + 1);

    logic [RED_BITS-1:0]        red_reg;
    logic [RED_BITS-1:0]        red_next;
    logic signed [ANGLE_BITS_P:0] wide;
    logic [PROD_BITS-1:0]       prod;
    logic [QUO_BITS-1:0]        quo;
    logic [RED_BITS-1:0]        rem_wide;
    logic [REM_BITS-1:0]        rem;
    logic [FRAC_BITS-1:0]       frac_tab [TURN_DIV];
    logic [FRAC_BITS-1:0]       frac;

    // angle lies in [-131072, 131071]: at most two turn corrections
    always_comb begin
        wide = {angle[ANGLE_BITS_P-1], angle};
        if (wide < 0) begin
            wide = wide + (ANGLE_BITS_P+1)'(svr_pkg::FULL_TURN_UNITS);
            if (wide < 0) begin
                wide = wide + (ANGLE_BITS_P+1)'(svr_pkg::FULL_TURN_UNITS);
            end
        end else if (wide >= (ANGLE_BITS_P+1)'(svr_pkg::FULL_TURN_UNITS)) begin
            wide = wide - (ANGLE_BITS_P+1)'(svr_pkg::FULL_TURN_UNITS);
        end
        red_next = wide[RED_BITS-1:0];
    end

    // rounded fraction of one 2^21 step for each remainder
    for (genvar m = 0; m < TURN_DIV; m++) begin : g_frac
        assign frac_tab[m] =
            FRAC_BITS'(((longint'(m) << FRAC_BITS) + longint'(TURN_DIV / 2)) / TURN_DIV);
    end

    // split by 45 through reciprocal, remainder picks the fraction
    always_comb begin
        prod     = PROD_BITS'(red_reg) * PROD_BITS'(RECIP);
        quo      = prod[RECIP_SHIFT +: QUO_BITS];
        rem_wide = red_reg - RED_BITS'(quo) * RED_BITS'(TURN_DIV);
        rem      = rem_wide[REM_BITS-1:0];
        frac     = frac_tab[rem];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= red_next;
            phase_reg <= {quo, frac};
        end
    end

endmodule

### rtl/core/svr_cordic.sv
// ----------------------------------------------------------------------------
// svr_cordic
// pipelined rotation-mode cordic, one stage per register, gives cos and sin
// ----------------------------------------------------------------------------
module svr_cordic #(
    parameter int STAGES = svr_pkg::CORDIC_STAGES
) (
    input  logic                                  aclk,
    input  logic                                  adv,
    input  logic [svr_pkg::PHASE_BITS-1:0]        phase,
    output logic signed [svr_pkg::TRIG_BITS-1:0]  cos_out,
    output logic signed [svr_pkg::TRIG_BITS-1:0]  sin_out
);

    localparam int RUN = (STAGES > svr_pkg::MAX_STAGES) ? svr_pkg::MAX_STAGES : STAGES;
    localparam int TB = svr_pkg::TRIG_BITS;

    logic signed [TB-1:0] x_reg [RUN+1];
    logic signed [TB-1:0] y_reg [RUN+1];
    logic signed [TB-1:0] z_reg [RUN+1];
    logic                 neg_reg [RUN+1];
    logic [svr_pkg::PHASE_BITS-1:0] folded;
    logic                 neg_next;

    always_comb begin
        neg_next = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        folded   = neg_next ? phase - 32'h80000000 : phase;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]   <= svr_pkg::CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= TB'(signed'(folded));
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < RUN; i++) begin : g_stage
        logic signed [TB-1:0] at;
        assign at = TB'(svr_pkg::atan_entry(i));
        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[i+1] <= neg_reg[i];
                if (!z_reg[i][TB-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - at;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    assign cos_out = neg_reg[RUN] ? -x_reg[RUN] : x_reg[RUN];
    assign sin_out = neg_reg[RUN] ? -y_reg[RUN] : y_reg[RUN];

endmodule

### rtl/core/svr_rot_step.sv
// ----------------------------------------------------------------------------
// svr_rot_step
// one axis rotation, or a pass-through when en is low: products, then rounded sum and saturation
// ----------------------------------------------------------------------------
module svr_rot_step #(
    parameter int COORD_BITS = svr_pkg::COORD_BITS
) (
    input  logic                                  aclk,
    input  logic                                  adv,
    input  logic                                  en,
    input  logic signed [COORD_BITS-1:0]          a_in,
    input  logic signed [COORD_BITS-1:0]          b_in,
    input  logic signed [svr_pkg::TRIG_BITS-1:0]  c_in,
    input  logic signed [svr_pkg::TRIG_BITS-1:0]  s_in,
    output logic signed [COORD_BITS-1:0]          a_reg,
    output logic signed [COORD_BITS-1:0]          b_reg,
    output logic                                  sat_reg
);

    localparam int TB = svr_pkg::TRIG_BITS;
    localparam int PB = COORD_BITS + TB;
    localparam int SB = PB + 1;

    logic en_reg;
    logic signed [PB-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [COORD_BITS-1:0] a_hold_reg, b_hold_reg;
    logic signed [SB-1:0] sum_a, sum_b, rnd_a, rnd_b;
    logic signed [SB-1:0] maxv, minv;
    logic signed [COORD_BITS-1:0] a_next, b_next;
    logic sat_next;

    // products are exact; as in the model, rounding acts on the full-width sum
    always_ff @(posedge aclk) begin
        if (adv) begin
            ac_reg     <= PB'(a_in) * PB'(c_in);
            bs_reg     <= PB'(b_in) * PB'(s_in);
            as_reg     <= PB'(a_in) * PB'(s_in);
            bc_reg     <= PB'(b_in) * PB'(c_in);
            a_hold_reg <= a_in;
            b_hold_reg <= b_in;
            en_reg     <= en;
        end
    end

    always_comb begin
        maxv   = SB'({1'b0, {(COORD_BITS-1){1'b1}}});
        minv   = -maxv - SB'(1);
        sum_a  = SB'(ac_reg) - SB'(bs_reg) + (SB'(1) <<< (svr_pkg::TRIG_FRAC - 1));
        sum_b  = SB'(as_reg) + SB'(bc_reg) + (SB'(1) <<< (svr_pkg::TRIG_FRAC - 1));
        rnd_a  = sum_a >>> svr_pkg::TRIG_FRAC;
        rnd_b  = sum_b >>> svr_pkg::TRIG_FRAC;
        sat_next = 1'b0;
        if (rnd_a > maxv) begin
            a_next = maxv[COORD_BITS-1:0]; sat_next = 1'b1;
        end else if (rnd_a < minv) begin
            a_next = minv[COORD_BITS-1:0]; sat_next = 1'b1;
        end else begin
            a_next = rnd_a[COORD_BITS-1:0];
        end
        if (rnd_b > maxv) begin
            b_next = maxv[COORD_BITS-1:0]; sat_next = 1'b1;
        end else if (rnd_b < minv) begin
            b_next = minv[COORD_BITS-1:0]; sat_next = 1'b1;
        end else begin
            b_next = rnd_b[COORD_BITS-1:0];
        end
        if (!en_reg) begin
            a_next   = a_hold_reg;
            b_next   = b_hold_reg;
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            sat_reg <= sat_next;
        end
    end

endmodule

### rtl/core/axis_select_vector_rotator_top.sv
// ----------------------------------------------------------------------------
// axis_select_vector_rotator_top
// 3d vector rotation about selected axes with pipelined cordic sin and cos
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one transfer carries angle, axis enables and a Q16.16 vector
//   m_ channel: one transfer per input carries the rotated vector and a
//   saturation flag, in input order
//   pipeline: 2 phase stages + 1 fold stage + CORDIC_STAGES cordic stages
//   + 3 x 2 rotation stages
//   throughput: one transfer per cycle while not stalled, set by the fully
//   pipelined cordic and rotation stages; every stage register holds one item
//   the whole pipeline moves as one: when the output register is full and
//   m_ready is low, all stages hold, and s_ready drops; nothing is lost
//   s_ready = m_ready or output empty, so a bubble in the pipe is not squeezed
//   reset: aresetn clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
`include "axis_select_vector_rotator_top_macros.svh"

module axis_select_vector_rotator_top #(
    parameter int CORDIC_STAGES = svr_pkg::CORDIC_STAGES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  svr_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output svr_pkg::out_item_t  m_data
);

    localparam int COORD_BITS = svr_pkg::COORD_BITS;
    localparam int RUN   = (CORDIC_STAGES > svr_pkg::MAX_STAGES) ? svr_pkg::MAX_STAGES
                                                               : CORDIC_STAGES;
    localparam int TRIG_LAT = 3 + RUN;
    localparam int DEPTH = TRIG_LAT + 6;
    localparam int TB = svr_pkg::TRIG_BITS;

    svr_pkg::flow_t  flow;
    logic            adv;
    logic [DEPTH-1:0] valid_reg;

    logic [svr_pkg::PHASE_BITS-1:0] phase;
    logic signed [TB-1:0] cos_v, sin_v;

    logic signed [COORD_BITS-1:0] dx_reg [TRIG_LAT];
    logic signed [COORD_BITS-1:0] dy_reg [TRIG_LAT];
    logic signed [COORD_BITS-1:0] dz_reg [TRIG_LAT];
    logic [2:0]                   ax_reg [TRIG_LAT];

    logic signed [TB-1:0] c1_reg, s1_reg, c2_reg, s2_reg, c3_reg, s3_reg;
    logic signed [TB-1:0] c4_reg, s4_reg;
    logic signed [COORD_BITS-1:0] x1_reg, x2_reg, z3_reg, z4_reg;
    logic [1:0] ax1_reg, ax2_reg;
    logic ax3_reg, ax4_reg;
    logic sat1_reg, sat2_reg;

    logic en_x, en_y, en_z;
    logic signed [COORD_BITS-1:0] ry_x, rz_x, rx_y, rz_y, rx_z, ry_z;
    logic sat_x, sat_y, sat_z;

    assign flow.valid = valid_reg[DEPTH-1];
    assign flow.ready = m_ready;
    assign adv     = flow.ready || !flow.valid;
    assign s_ready = adv;
    assign m_valid = flow.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    svr_phase u_phase (
        .aclk      (aclk),
        .adv       (adv),
        .angle     (s_data.angle),
        .phase_reg (phase)
    );

    svr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .aclk    (aclk),
        .adv     (adv),
        .phase   (phase),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    // vector and enables ride alongside the trig pipeline
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg[0] <= COORD_BITS'(s_data.vec_x);
            dy_reg[0] <= COORD_BITS'(s_data.vec_y);
            dz_reg[0] <= COORD_BITS'(s_data.vec_z);
            ax_reg[0] <= {s_data.use_x_axis, s_data.use_y_axis, s_data.use_z_axis};
            for (int i = 1; i < TRIG_LAT; i++) begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
                dz_reg[i] <= dz_reg[i-1];
                ax_reg[i] <= ax_reg[i-1];
            end
        end
    end

    assign en_x = ax_reg[TRIG_LAT-1][2];

    svr_rot_step #(.COORD_BITS(COORD_BITS)) u_rot_x (
        .aclk (aclk), .adv (adv), .en (en_x),
        .a_in (dy_reg[TRIG_LAT-1]), .b_in (dz_reg[TRIG_LAT-1]),
        .c_in (cos_v), .s_in (sin_v),
        .a_reg (ry_x), .b_reg (rz_x), .sat_reg (sat_x)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            c1_reg <= cos_v;  s1_reg <= sin_v;
            c2_reg <= c1_reg; s2_reg <= s1_reg;
            x1_reg <= dx_reg[TRIG_LAT-1]; x2_reg <= x1_reg;
            ax1_reg <= ax_reg[TRIG_LAT-1][1:0]; ax2_reg <= ax1_reg;
        end
    end

    assign en_y = ax2_reg[1];

    svr_rot_step #(.COORD_BITS(COORD_BITS)) u_rot_y (
        .aclk (aclk), .adv (adv), .en (en_y),
        .a_in (x2_reg), .b_in (rz_x), .c_in (c2_reg), .s_in (s2_reg),
        .a_reg (rx_y), .b_reg (rz_y), .sat_reg (sat_y)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            c3_reg <= c2_reg; s3_reg <= s2_reg;
            c4_reg <= c3_reg; s4_reg <= s3_reg;
            z3_reg <= ry_x;   z4_reg <= z3_reg;
            ax3_reg <= ax2_reg[0]; ax4_reg <= ax3_reg;
            sat1_reg <= sat_x; sat2_reg <= sat1_reg;
        end
    end

    assign en_z = ax4_reg;

    svr_rot_step #(.COORD_BITS(COORD_BITS)) u_rot_z (
        .aclk (aclk), .adv (adv), .en (en_z),
        .a_in (rx_y), .b_in (z4_reg), .c_in (c4_reg), .s_in (s4_reg),
        .a_reg (rx_z), .b_reg (ry_z), .sat_reg (sat_z)
    );

    // z of y step passes through zf1_reg and zf2_reg to meet the z step output
    logic signed [COORD_BITS-1:0] zf1_reg, zf2_reg;
    logic satf1_reg, satf2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            zf1_reg   <= rz_y;     zf2_reg   <= zf1_reg;
            satf1_reg <= sat2_reg || sat_y;
            satf2_reg <= satf1_reg;
        end
    end

    assign m_data.out_x     = svr_pkg::COORD_BITS'(rx_z);
    assign m_data.out_y     = svr_pkg::COORD_BITS'(ry_z);
    assign m_data.out_z     = svr_pkg::COORD_BITS'(zf2_reg);
    assign m_data.saturated = satf2_reg || sat_z;

    `SVR_ASSERT(a_stall_holds_out, m_valid && !m_ready |=> m_valid && $stable(m_data),
        "result changed while stalled")
    `SVR_ASSERT(a_ready_when_empty, !m_valid |-> s_ready, "input blocked with empty output")
    `SVR_ASSERT(a_no_take_when_full, m_valid && !m_ready |-> !s_ready,
        "input taken while pipeline frozen")
    `SVR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "valid after reset")

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the selected-axis vector rotator against a bit-exact cordic predictor
// with random idling on both channels, directed corner cases and random traffic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class rotation_scoreboard;
    svr_pkg::out_item_t pending_q[$];
    int mismatches;
    int atan_tab[32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    function void trig(input longint ang, output longint c, output longint s);
        longint r, z;
        longint unsigned ph;
        bit flip;
        c = 64'sh26DD3B6A;
        s = 0;
        flip = 0;
        r = ang % 92160;
        if (r < 0) r += 92160;
        ph = ((longint'(r) << 21) + 22) / 45;
        ph &= 64'hFFFF_FFFF;
        if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) begin
            ph = (ph - 64'h8000_0000) & 64'hFFFF_FFFF;
            flip = 1;
        end
        z = ph[31] ? longint'(ph) - 64'sh1_0000_0000 : longint'(ph);
        for (int i = 0; i < svr_pkg::CORDIC_STAGES && i < 32; i++) begin
            longint dx, dy;
            dx = s >>> i;
            dy = c >>> i;
            if (z >= 0) begin
                c -= dx; s += dy; z -= atan_tab[i];
            end else begin
                c += dx; s -= dy; z += atan_tab[i];
            end
        end
        if (flip) begin
            c = -c; s = -s;
        end
    endfunction

    // exact 128-bit sum, rounded half up from q2.30
    function longint combine(longint a, longint p, longint b, longint q, inout bit sat);
        logic signed [127:0] acc;
        longint v;
        acc = 128'(signed'(a)) * 128'(signed'(p)) + 128'(signed'(b)) * 128'(signed'(q));
        acc = (acc + (128'sd1 <<< 29)) >>> 30;
        if (acc > 128'sd2147483647) begin
            sat = 1; return 64'sd2147483647;
        end
        if (acc < -128'sd2147483648) begin
            sat = 1; return -64'sd2147483648;
        end
        v = longint'(acc);
        return v;
    endfunction

    function void turn(inout longint a, inout longint b, input longint c, input longint s,
                       inout bit sat);
        longint na, nb;
        na = combine(a, c, b, -s, sat);
        nb = combine(a, s, b, c, sat);
        a = na; b = nb;
    endfunction

    function void note_input(svr_pkg::in_item_t it);
        longint c, s, x, y, z;
        bit sat;
        svr_pkg::out_item_t r;
        sat = 0;
        x = it.vec_x; y = it.vec_y; z = it.vec_z;
        trig(longint'(it.angle), c, s);
        if (it.use_x_axis) turn(y, z, c, s, sat);
        if (it.use_y_axis) turn(x, z, c, s, sat);
        if (it.use_z_axis) turn(x, y, c, s, sat);
        r.out_x = x[31:0]; r.out_y = y[31:0]; r.out_z = z[31:0]; r.saturated = sat;
        pending_q.push_back(r);
    endfunction

    function void check_result(svr_pkg::out_item_t got);
        svr_pkg::out_item_t want;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer %h", got);
            return;
        end
        want = pending_q.pop_front();
        if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
            got.out_z !== want.out_z || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                         want.out_x, want.out_y, want.out_z, want.saturated,
                         got.out_x, got.out_y, got.out_z, got.saturated);
        end
    endfunction
endclass

module tb;
    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    svr_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    svr_pkg::out_item_t m_data;

    rotation_scoreboard rotations = new();
    int cycle_count = 0;

    axis_select_vector_rotator_top dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("axis_select_vector_rotator_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) rotations.note_input(s_data);
        if (aresetn && m_valid && m_ready) rotations.check_result(m_data);
    end

    // valid stays high into the next transfer when there is no gap
    task automatic send_vector(svr_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
        endcase
    endfunction

    function automatic svr_pkg::in_item_t make_vector(logic [17:0] ang, logic [2:0] axes,
                                                     logic [31:0] x, logic [31:0] y,
                                                     logic [31:0] z);
        svr_pkg::in_item_t it;
        it.angle = ang;
        {it.use_x_axis, it.use_y_axis, it.use_z_axis} = axes;
        it.vec_x = x; it.vec_y = y; it.vec_z = z;
        return it;
    endfunction

    // receiver stall pattern, with stretches of no stalls
    initial begin
        int stall;
        repeat (10) @(posedge aclk);
        forever begin
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [17:0] angles[12];
        angles = '{18'h0, 18'd23040, 18'd46080, 18'd69120, 18'd92160,
            -18'sd92160, 18'h1FFFF, 18'h20000, 18'h3FFFF, 18'd11520, -18'sd23040, 18'd92159};
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int i = 0; i < 8; i++)
            send_vector(make_vector(angles[i % 12], i[2:0], 32'h00010000,
                                    32'hFFFF0000, 32'h00020000));
        for (int i = 0; i < 12; i++)
            send_vector(make_vector(angles[i], 3'b111, 32'h7FFFFFFF, 32'h80000000,
                                    32'h7FFFFFFF));
        send_vector(make_vector(18'd5760, 3'b000, 32'h80000000, 32'h7FFFFFFF, 32'h0));
        send_vector(make_vector(18'd5760, 3'b100, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0));
        s_valid <= 0;
        // let everything drain once before the random part
        while (rotations.pending_q.size() != 0) @(posedge aclk);
        for (int n = 0; n < 950; n++) begin
            logic [17:0] ang;
            if ($urandom_range(0, 3) == 0) ang = 18'($urandom());
            else ang = 18'($signed($urandom_range(0, 184320)) - 92160);
            send_vector(make_vector(ang, 3'($urandom()), rand_coord(), rand_coord(),
                                    rand_coord()));
        end
        s_valid <= 0;
        while (rotations.pending_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (rotations.mismatches == 0 && rotations.pending_q.size() == 0)
            $display("axis_select_vector_rotator_top test passed");
        else
            $display("axis_select_vector_rotator_top test failed");
        $finish;
    end
endmodule
